/* rtl/hpd_pkg.sv */
`default_nettype none

package hpd_pkg;

   localparam int PHASE_DENOM = 12;
   localparam int PIXEL_W     = 8;
   localparam int STEP_W      = 4;
   localparam int PHASE_W     = 4;
   localparam int SUM_W       = PHASE_W + 1;
   localparam int LEAD_W      = 2;
   localparam int PROD_W      = PIXEL_W + STEP_W;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int QPROD_W     = PROD_W + RECIP_W;

   localparam logic [STEP_W-1:0]  MAX_STEP      = STEP_W'(PHASE_DENOM - 1);
   localparam logic [STEP_W-1:0]  RESET_STEP    = STEP_W'(11);
   localparam logic [SUM_W-1:0]   DENOM_SUM     = SUM_W'(PHASE_DENOM);
   localparam logic [LEAD_W-1:0]  LEAD_PASS     = LEAD_W'(2);
   localparam logic [LEAD_W-1:0]  LEAD_STEADY   = LEAD_W'(3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_SCALE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic multiply;
      logic scale;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

   // ceil(2^16 / d); exact quotient for products below 2^12 and d up to 12
   function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         4'd10:   r = 17'd6554;
         4'd11:   r = 17'd5958;
         4'd12:   r = 17'd5462;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/hpd_ctrl.sv */
`default_nettype none

module hpd_ctrl
   import hpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   output logic            req_stall,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.emit) state_in = ST_MULT;
         end
         ST_MULT:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SEND;
         ST_SEND: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_MULT:  cmd.multiply = 1'b1;
         ST_SCALE: cmd.scale    = 1'b1;
         ST_SEND:  cmd.load_out = status.out_free;
         default:  req_stall    = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/hpd_datapath.sv */
`default_nettype none

module hpd_datapath
   import hpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [PIXEL_W-1:0] req_pixel_in,
   input  wire logic               req_last_in_line,
   input  wire logic               csr_write_enable,
   input  wire logic [STEP_W-1:0]  csr_write_data,
   input  wire logic               rsp_stall,
   output status_type              status,
   output logic                    rsp_valid,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_from_last_input
);

   logic [STEP_W-1:0]  scale_step_ff;
   logic [LEAD_W-1:0]  lead_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [PIXEL_W-1:0] prev_ff;

   logic [PIXEL_W-1:0] cur_ff;
   logic               down_ff;
   logic [PIXEL_W-1:0] diff_ff;
   logic [STEP_W-1:0]  rem_ff;
   logic [STEP_W-1:0]  div_ff;
   logic               last_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [PIXEL_W-1:0] mag_ff;

   logic               valid_ff;
   logic [PIXEL_W-1:0] pixel_out_ff;
   logic               from_last_ff;

   logic [STEP_W-1:0]  step_eff;
   logic [STEP_W-1:0]  inc;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   sum_wrap;
   logic               wrap;
   logic               emit;
   logic [PHASE_W-1:0] phase_in;
   logic [LEAD_W-1:0]  lead_in;
   logic [STEP_W-1:0]  rem_in;
   logic [QPROD_W-1:0] qprod;

   always_comb begin
      step_eff = (scale_step_ff > MAX_STEP) ? MAX_STEP : scale_step_ff;
      inc      = step_eff + STEP_W'(1);
      sum      = SUM_W'(phase_ff) + SUM_W'(inc);
      wrap     = (sum >= DENOM_SUM);
      sum_wrap = sum - DENOM_SUM;
      emit     = 1'b0;
      lead_in  = lead_ff;
      phase_in = phase_ff;
      rem_in   = '0;
      if (lead_ff < LEAD_PASS) begin
         lead_in = lead_ff + LEAD_W'(1);
      end else if (lead_ff == LEAD_PASS) begin
         lead_in = LEAD_STEADY;
         emit    = 1'b1;
      end else if (wrap) begin
         emit     = 1'b1;
         phase_in = sum_wrap[PHASE_W-1:0];
         rem_in   = sum_wrap[STEP_W-1:0];
      end else begin
         phase_in = sum[PHASE_W-1:0];
      end
   end

   assign qprod = QPROD_W'(prod_ff) * QPROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_step_ff <= RESET_STEP;
      end else if (csr_write_enable) begin
         scale_step_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         phase_ff <= '0;
         prev_ff  <= '0;
      end else if (cmd.accept) begin
         if (req_last_in_line) begin
            lead_ff  <= '0;
            phase_ff <= '0;
            prev_ff  <= '0;
         end else begin
            lead_ff  <= lead_in;
            phase_ff <= phase_in;
            if (emit) prev_ff <= req_pixel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit) begin
         cur_ff  <= req_pixel_in;
         down_ff <= (prev_ff < req_pixel_in);
         diff_ff <= (prev_ff < req_pixel_in) ? (req_pixel_in - prev_ff)
                                             : (prev_ff - req_pixel_in);
         rem_ff  <= rem_in;
         div_ff  <= inc;
         last_ff <= req_last_in_line;
      end
      if (cmd.multiply) begin
         prod_ff  <= PROD_W'(diff_ff) * PROD_W'(rem_ff);
         recip_ff <= recip(div_ff);
      end
      if (cmd.scale) begin
         mag_ff <= qprod[RECIP_SHIFT +: PIXEL_W];
      end
      if (cmd.load_out) begin
         pixel_out_ff <= down_ff ? (cur_ff - mag_ff) : (cur_ff + mag_ff);
         from_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.emit         = emit;
   assign status.out_free     = !valid_ff || !rsp_stall;
   assign rsp_valid           = valid_ff;
   assign rsp_pixel_out       = pixel_out_ff;
   assign rsp_from_last_input = from_last_ff;

endmodule

`default_nettype wire

/* rtl/horizontal_pixel_downscaler_top.sv */
// channel  | direction | handshake          | payload
// req      | in        | req_valid/stall    | pixel_in, last_in_line
// rsp      | out       | rsp_valid/stall    | pixel_out, from_last_input
// csr      | in        | csr_write_enable   | write_data (scale_step)
//
// A pixel that yields no output is taken without a stall and the next can follow at once.
// A pixel that yields an output holds req_stall through the multiply,
// reciprocal scale and output load states, so no new pixel is taken until it is loaded.
// rsp_stall holds the output register and the controller waits in its load state.
// Synchronous reset clears line state, the output valid and sets scale_step to 11.
`default_nettype none

module horizontal_pixel_downscaler_top
   import hpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [PIXEL_W-1:0] req_pixel_in,
   input  wire logic               req_last_in_line,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_from_last_input,
   input  wire logic               csr_write_enable,
   input  wire logic [STEP_W-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   hpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   hpd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_pixel_in        (req_pixel_in),
      .req_last_in_line    (req_last_in_line),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_stall           (rsp_stall),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_from_last_input (rsp_from_last_input)
   );

endmodule

`default_nettype wire

/* rtl/hpd_checker.sv */
`default_nettype none

module hpd_checker
   import hpd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [PIXEL_W-1:0] rsp_pixel_out,
   input wire logic               rsp_from_last_input
);

   // held output transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                && $stable(rsp_from_last_input))
      else $error("rsp payload changed while stalled");

   // an output is loaded only from the busy load state
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp_valid rose without a busy cycle before it");

   // a new output never appears in the cycle right after an input transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("rsp_valid rose too soon after an input transfer");

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind horizontal_pixel_downscaler_top hpd_checker u_hpd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_pixel_out       (rsp_pixel_out),
   .rsp_from_last_input (rsp_from_last_input)
);

`default_nettype wire

/* tb/horizontal_pixel_downscaler_top_tb.sv */
`default_nettype none

module horizontal_pixel_downscaler_top_tb;
   import hpd_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LINE_DENOM   = 12;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               from_last;
   } scaled_pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIXEL_W-1:0] req_pixel_in = '0;
   logic               req_last_in_line = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PIXEL_W-1:0] rsp_pixel_out;
   logic               rsp_from_last_input;
   logic               csr_write_enable = 1'b0;
   logic [STEP_W-1:0]  csr_write_data = '0;

   scaled_pixel_type predicted_pixels[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            stall_left = 0;
   bit            sender_gaps_on = 1'b1;
   bit            sink_stalls_on = 1'b1;

   // line state mirror
   logic [1:0]         line_lead = '0;
   int                 line_phase = 0;
   logic [PIXEL_W-1:0] line_prev = '0;
   logic [STEP_W-1:0]  active_step = 4'd11;

   horizontal_pixel_downscaler_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_in        (req_pixel_in),
      .req_last_in_line    (req_last_in_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_from_last_input (rsp_from_last_input),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      scaled_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: pixel_out=%0d from_last_input=%0b",
                        rsp_pixel_out, rsp_from_last_input);
         end else begin
            want = predicted_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_from_last_input !== want.from_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected pixel_out=%0d from_last_input=%0b, got %0d %0b",
                           want.pixel, want.from_last, rsp_pixel_out, rsp_from_last_input);
            end
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] blend_pixel(input int cur, input int prev,
                                                      input int rem, input int div);
      if (prev >= cur)
         return PIXEL_W'(cur + ((prev - cur) * rem) / div);
      return PIXEL_W'(cur - ((cur - prev) * rem) / div);
   endfunction

   task automatic downscale_pixel(input logic [PIXEL_W-1:0] cur, input logic last);
      int            inc;
      int            sum;
      bit            emit;
      scaled_pixel_type res;
      inc = ((active_step > 4'd11) ? 11 : int'(active_step)) + 1;
      emit = 1'b0;
      res.from_last = last;
      res.pixel = cur;
      if (line_lead < 2) begin
         line_lead = line_lead + 2'd1;
      end else if (line_lead == 2) begin
         line_lead = 2'd3;
         emit = 1'b1;
      end else begin
         sum = line_phase + inc;
         if (sum >= LINE_DENOM) begin
            sum -= LINE_DENOM;
            emit = 1'b1;
            if (sum != 0)
               res.pixel = blend_pixel(int'(cur), int'(line_prev), sum, inc);
         end
         line_phase = sum;
      end
      if (emit) begin
         line_prev = cur;
         predicted_pixels = {predicted_pixels, res};
      end
      if (last) begin
         line_lead = '0;
         line_phase = 0;
         line_prev = '0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (!sender_gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      req_last_in_line <= last;
      do @(posedge clock); while (req_stall);
      downscale_pixel(pix, last);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_pixels.size() != 0);
   endtask

   task automatic write_scale_step(input logic [STEP_W-1:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_step = value;
   endtask

   // reset step passes every pixel after the two dropped ones
   task automatic test_pass_through();
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b1);
   endtask

   // last marker on each of the leading pixels
   task automatic test_leading_last();
      send_pixel(8'd10, 1'b1);
      send_pixel(8'd20, 1'b0);
      send_pixel(8'd30, 1'b1);
      send_pixel(8'd40, 1'b0);
      send_pixel(8'd50, 1'b0);
      send_pixel(8'd60, 1'b1);
   endtask

   // last pixel falls on a skipped position
   task automatic test_skipped_last();
      write_scale_step(4'd5);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd8, 1'b0);
      send_pixel(8'd9, 1'b0);
      send_pixel(8'd10, 1'b1);
   endtask

   // blend toward a brighter and a darker previous pixel
   task automatic test_interpolation();
      write_scale_step(4'd6);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd9, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd9, 1'b0);
      send_pixel(8'd255, 1'b1);
   endtask

   // steps above 11 behave as 11
   task automatic test_step_above_range();
      write_scale_step(4'd15);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd2, 1'b0);
      send_pixel(8'd3, 1'b0);
      send_pixel(8'd4, 1'b1);
   endtask

   // random lines; phases end mid-line so steps also change inside a line
   task automatic test_random_lines();
      logic [STEP_W-1:0]  phase_steps[5] = '{4'd0, 4'd11, 4'd15, 4'd12, 4'd1};
      int                 line_left;
      int                 r;
      logic [PIXEL_W-1:0] pix;
      line_left = 0;
      for (int p = 0; p < 10; p++) begin
         sender_gaps_on = (p % 3 != 1);
         sink_stalls_on = (p % 4 != 2);
         write_scale_step((p < 5) ? phase_steps[p] : STEP_W'($urandom_range(0, 15)));
         for (int i = 0; i < 110; i++) begin
            if (line_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 15)
                  line_left = $urandom_range(1, 3);
               else if (r < 85)
                  line_left = $urandom_range(4, 20);
               else
                  line_left = $urandom_range(21, 60);
            end
            r = $urandom_range(0, 7);
            pix = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : PIXEL_W'($urandom_range(0, 255));
            send_pixel(pix, line_left == 1);
            line_left--;
            if (p == 4 && i == 55)
               wait_results_drained();
         end
      end
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pass_through();
      test_leading_last();
      test_skipped_last();
      test_interpolation();
      test_step_above_range();
      test_random_lines();
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* horizontal_pixel_downscaler_top.f */
rtl/hpd_pkg.sv
rtl/hpd_ctrl.sv
rtl/hpd_datapath.sv
rtl/horizontal_pixel_downscaler_top.sv
rtl/hpd_checker.sv
tb/horizontal_pixel_downscaler_top_tb.sv
